FILE: src/rgb_to_hsv_converter_core_defines.svh
// Assertion macros for the RGB to HSV converter core.
`ifndef RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define RGBHSV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgbhsv: implication check failed");

// Checks that a transfer in comes out after the fixed pipeline latency.
`define RGBHSV_ASSERT_LAT(label, ante, cons, lat) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(lat) (cons)) \
        else $error("rgbhsv: latency check failed");

`endif

FILE: src/rgbhsv_pkg.sv
// Package with types and constants of the RGB to HSV converter core.
`default_nettype none

package rgbhsv_pkg;

    localparam int CH_W           = 8;
    localparam int HUE_W          = 16;
    localparam int SAT_W          = 16;
    localparam int QUOT_W         = 16;
    localparam int DEN_W          = 11;
    localparam int DIFF_W         = CH_W + 1;
    localparam int SUM_W          = DEN_W + 1;
    localparam int SNUM_W         = CH_W + QUOT_W;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = QUOT_W / DIV_STAGES;
    localparam int LATENCY        = DIV_STAGES + 3;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [CH_W-1:0]  value;
    } t_hsv;

endpackage

`default_nettype wire

FILE: src/rgb_to_hsv_converter_core.sv
// Top level of the pipelined RGB to HSV pixel converter.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+----------------------------------
//   pixel in | start, busy        | i_pixel (red, green, blue)
//   result   | o_valid (strobe)   | o_result (hue, saturation, value)
//
// A pixel is accepted in every cycle that start is high; busy is always low.
// Each result passes from its transfer in through two stages for max,
// min, chroma, hue sector and divider operands, four divider stages of
// four quotient bits each, and one output stage.
// Synchronous reset clears only the valid bits; results are strobed and
// the receiver cannot stall, so nothing is held back.
`default_nettype none

module rgb_to_hsv_converter_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire rgbhsv_pkg::t_rgb  i_pixel,
    output logic                   o_valid,
    output rgbhsv_pkg::t_hsv       o_result
);

    `include "rgb_to_hsv_converter_core_defines.svh"

    logic                            accept;
    logic [rgbhsv_pkg::CH_W-1:0]     n1_v;
    logic [rgbhsv_pkg::CH_W-1:0]     n1_min;
    logic [1:0]                      n1_sec;
    logic signed [rgbhsv_pkg::DIFF_W-1:0] n1_diff;

    logic                            r1_valid;
    logic [rgbhsv_pkg::CH_W-1:0]     r1_v;
    logic [rgbhsv_pkg::CH_W-1:0]     r1_c;
    logic [1:0]                      r1_sec;
    logic signed [rgbhsv_pkg::DIFF_W-1:0] r1_diff;

    logic signed [rgbhsv_pkg::SUM_W-1:0] n2_sum;
    logic [rgbhsv_pkg::SUM_W-1:0]    n2_offc;

    logic                            r2_valid;
    logic [rgbhsv_pkg::DEN_W-1:0]    r2_hmag;
    logic                            r2_hneg;
    logic [rgbhsv_pkg::DEN_W-1:0]    r2_hden;
    logic [rgbhsv_pkg::SNUM_W-1:0]   r2_snum;
    logic [rgbhsv_pkg::CH_W-1:0]     r2_v;
    logic                            r2_czero;
    logic                            r2_vzero;

    logic                            r_pvalid [rgbhsv_pkg::DIV_STAGES];
    logic                            r_pneg   [rgbhsv_pkg::DIV_STAGES];
    logic                            r_pczero [rgbhsv_pkg::DIV_STAGES];
    logic                            r_pvzero [rgbhsv_pkg::DIV_STAGES];
    logic [rgbhsv_pkg::CH_W-1:0]     r_pv     [rgbhsv_pkg::DIV_STAGES];

    logic [rgbhsv_pkg::QUOT_W-1:0]   hue_quot;
    logic [rgbhsv_pkg::QUOT_W-1:0]   sat_quot;
    rgbhsv_pkg::t_hsv                n_result;
    rgbhsv_pkg::t_hsv                r_result;
    logic                            r_valid;

    localparam int LAST = rgbhsv_pkg::DIV_STAGES - 1;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage one: value, minimum and hue sector with blue over green over red.
    always_comb begin
        n1_v   = (i_pixel.red > i_pixel.green) ? i_pixel.red : i_pixel.green;
        n1_v   = (n1_v > i_pixel.blue) ? n1_v : i_pixel.blue;
        n1_min = (i_pixel.red < i_pixel.green) ? i_pixel.red : i_pixel.green;
        n1_min = (n1_min < i_pixel.blue) ? n1_min : i_pixel.blue;
        if (n1_v == i_pixel.blue) begin
            n1_sec  = rgbhsv_pkg::SEC_BLUE;
            n1_diff = $signed({1'b0, i_pixel.red}) - $signed({1'b0, i_pixel.green});
        end else if (n1_v == i_pixel.green) begin
            n1_sec  = rgbhsv_pkg::SEC_GREEN;
            n1_diff = $signed({1'b0, i_pixel.blue}) - $signed({1'b0, i_pixel.red});
        end else begin
            n1_sec  = rgbhsv_pkg::SEC_RED;
            n1_diff = $signed({1'b0, i_pixel.green}) - $signed({1'b0, i_pixel.blue});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
        r1_v    <= n1_v;
        r1_c    <= n1_v - n1_min;
        r1_sec  <= n1_sec;
        r1_diff <= n1_diff;
    end

    // Stage two: signed hue numerator, hue divisor and saturation numerator.
    always_comb begin
        case (r1_sec)
            rgbhsv_pkg::SEC_BLUE:  n2_offc = {2'b00, r1_c, 2'b00};
            rgbhsv_pkg::SEC_GREEN: n2_offc = {3'b000, r1_c, 1'b0};
            default:               n2_offc = '0;
        endcase
        n2_sum = $signed(n2_offc) + rgbhsv_pkg::SUM_W'(r1_diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_hneg  <= n2_sum[rgbhsv_pkg::SUM_W-1];
        r2_hmag  <= n2_sum[rgbhsv_pkg::SUM_W-1]
                    ? rgbhsv_pkg::DEN_W'(-n2_sum) : n2_sum[rgbhsv_pkg::DEN_W-1:0];
        r2_hden  <= {1'b0, r1_c, 2'b00} + {2'b00, r1_c, 1'b0};
        r2_snum  <= {r1_c, {rgbhsv_pkg::QUOT_W{1'b0}}}
                    - rgbhsv_pkg::SNUM_W'(r1_c);
        r2_v     <= r1_v;
        r2_czero <= (r1_c == '0);
        r2_vzero <= (r1_v == '0);
    end

    rgbhsv_div u_hue_div (
        .i_clk    (i_clk),
        .i_num_hi (r2_hmag),
        .i_num_lo ('0),
        .i_den    (r2_hden),
        .o_quot   (hue_quot)
    );

    rgbhsv_div u_sat_div (
        .i_clk    (i_clk),
        .i_num_hi (rgbhsv_pkg::DEN_W'(r2_snum[rgbhsv_pkg::SNUM_W-1:rgbhsv_pkg::QUOT_W])),
        .i_num_lo (r2_snum[rgbhsv_pkg::QUOT_W-1:0]),
        .i_den    (rgbhsv_pkg::DEN_W'(r2_v)),
        .o_quot   (sat_quot)
    );

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < rgbhsv_pkg::DIV_STAGES; s++) begin
            if (!i_rst_n) begin
                r_pvalid[s] <= 1'b0;
            end else if (s == 0) begin
                r_pvalid[s] <= r2_valid;
            end else begin
                r_pvalid[s] <= r_pvalid[s-1];
            end
            if (s == 0) begin
                r_pneg[s]   <= r2_hneg;
                r_pczero[s] <= r2_czero;
                r_pvzero[s] <= r2_vzero;
                r_pv[s]     <= r2_v;
            end else begin
                r_pneg[s]   <= r_pneg[s-1];
                r_pczero[s] <= r_pczero[s-1];
                r_pvzero[s] <= r_pvzero[s-1];
                r_pv[s]     <= r_pv[s-1];
            end
        end
    end

    // A negative hue wraps by one full turn, which is negation in 16 bits.
    always_comb begin
        if (r_pczero[LAST]) begin
            n_result.hue = '0;
        end else if (r_pneg[LAST]) begin
            n_result.hue = rgbhsv_pkg::HUE_W'(-hue_quot);
        end else begin
            n_result.hue = hue_quot;
        end
        n_result.saturation = r_pvzero[LAST] ? '0 : sat_quot;
        n_result.value      = r_pv[LAST];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_pvalid[LAST];
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `RGBHSV_ASSERT_LAT(a_latency, start && !busy, o_valid, rgbhsv_pkg::LATENCY)
    `RGBHSV_ASSERT_IMPL(a_grey_hue, o_valid && o_result.saturation == '0, o_result.hue == '0)
    `RGBHSV_ASSERT_IMPL(a_black_sat, o_valid && o_result.value == '0, o_result.saturation == '0)

endmodule

`default_nettype wire

FILE: src/rgbhsv_div.sv
// Pipelined restoring divider giving a fixed number of quotient bits per stage.
`default_nettype none

module rgbhsv_div (
    input  wire logic                          i_clk,
    input  wire logic [rgbhsv_pkg::DEN_W-1:0]  i_num_hi,
    input  wire logic [rgbhsv_pkg::QUOT_W-1:0] i_num_lo,
    input  wire logic [rgbhsv_pkg::DEN_W-1:0]  i_den,
    output logic      [rgbhsv_pkg::QUOT_W-1:0] o_quot
);

    logic [rgbhsv_pkg::DEN_W-1:0]  r_rem  [rgbhsv_pkg::DIV_STAGES];
    logic [rgbhsv_pkg::QUOT_W-1:0] r_lo   [rgbhsv_pkg::DIV_STAGES];
    logic [rgbhsv_pkg::DEN_W-1:0]  r_den  [rgbhsv_pkg::DIV_STAGES];
    logic [rgbhsv_pkg::QUOT_W-1:0] r_quot [rgbhsv_pkg::DIV_STAGES];
    logic [rgbhsv_pkg::DEN_W-1:0]  n_rem  [rgbhsv_pkg::DIV_STAGES];
    logic [rgbhsv_pkg::QUOT_W-1:0] n_lo   [rgbhsv_pkg::DIV_STAGES];
    logic [rgbhsv_pkg::DEN_W-1:0]  n_den  [rgbhsv_pkg::DIV_STAGES];
    logic [rgbhsv_pkg::QUOT_W-1:0] n_quot [rgbhsv_pkg::DIV_STAGES];

    // The partial remainder stays below the divisor whenever i_num_hi starts
    // below it, so one extra bit holds the shifted trial value.
    always_comb begin
        logic [rgbhsv_pkg::DEN_W-1:0]  rem;
        logic [rgbhsv_pkg::QUOT_W-1:0] lo;
        logic [rgbhsv_pkg::DEN_W-1:0]  den;
        logic [rgbhsv_pkg::QUOT_W-1:0] quot;
        logic [rgbhsv_pkg::DEN_W:0]    trial;
        for (int s = 0; s < rgbhsv_pkg::DIV_STAGES; s++) begin
            if (s == 0) begin
                rem  = i_num_hi;
                lo   = i_num_lo;
                den  = i_den;
                quot = '0;
            end else begin
                rem  = r_rem[s-1];
                lo   = r_lo[s-1];
                den  = r_den[s-1];
                quot = r_quot[s-1];
            end
            for (int b = 0; b < rgbhsv_pkg::BITS_PER_STAGE; b++) begin
                trial = {rem, lo[rgbhsv_pkg::QUOT_W-1]};
                lo    = {lo[rgbhsv_pkg::QUOT_W-2:0], 1'b0};
                if (trial >= {1'b0, den}) begin
                    rem  = rgbhsv_pkg::DEN_W'(trial - {1'b0, den});
                    quot = {quot[rgbhsv_pkg::QUOT_W-2:0], 1'b1};
                end else begin
                    rem  = trial[rgbhsv_pkg::DEN_W-1:0];
                    quot = {quot[rgbhsv_pkg::QUOT_W-2:0], 1'b0};
                end
            end
            n_rem[s]  = rem;
            n_lo[s]   = lo;
            n_den[s]  = den;
            n_quot[s] = quot;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < rgbhsv_pkg::DIV_STAGES; s++) begin
            r_rem[s]  <= n_rem[s];
            r_lo[s]   <= n_lo[s];
            r_den[s]  <= n_den[s];
            r_quot[s] <= n_quot[s];
        end
    end

    assign o_quot = r_quot[rgbhsv_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire
